@@ rtl/e2q_pkg.sv @@
// ----------------------------------------------------------------------------
// e2q_pkg: shared constants for the Euler-to-quaternion pipeline
// Angle table for the CORDIC (binary angle units, 2^32 per turn), its length and the inverse CORDIC gain.
// ----------------------------------------------------------------------------
`default_nettype none
package e2q_pkg;
  localparam int TABLE_LEN = 24;
  localparam longint KINF_Q30 = 64'd652032874;

  // atan(2^-i) as a 32-bit binary angle
  function automatic logic [31:0] atan_bam(input int i);
    logic [31:0] t;
    begin
      case (i)
        0: t = 32'h20000000; 1: t = 32'h12E4051D; 2: t = 32'h09FB385B;
        3: t = 32'h051111D4; 4: t = 32'h028B0D43; 5: t = 32'h0145D7E1;
        6: t = 32'h00A2F61E; 7: t = 32'h00517C55; 8: t = 32'h0028BE53;
        9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
        12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
        15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
        18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
        21: t = 32'h00000146; 22: t = 32'h000000A3; default: t = 32'h00000051;
      endcase
      return t;
    end
  endfunction
endpackage
`default_nettype wire

@@ rtl/euler_angles_to_quaternion_unit.sv @@
// ----------------------------------------------------------------------------
// euler_angles_to_quaternion_unit: yaw-pitch-roll angles to unit quaternion
// Pipelined angle scaling, unrolled CORDIC stages and quaternion products.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)
//  in_     | in  | roll_deg[16:0], pitch_deg[33:17], yaw_deg[50:34], pad to 56
//  out_    | out | quat_scalar, quat_i, quat_j, quat_k (16 bits each)
//
// One item per cycle while out_tready is high or the output is empty; the
// pipeline stages are angle scale 2, CORDIC load 1, CORDIC one step per stage
// (steps capped at 24), quadrant 1, products 4, round 1. Synchronous active-low
// reset clears all valid bits. A stall on out_tready freezes the whole pipeline;
// in_tready follows the output side, so nothing is dropped or repeated.
`default_nettype none
module euler_angles_to_quaternion_unit #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // roll_deg, pitch_deg, yaw_deg
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata   // quat_scalar, quat_i, quat_j, quat_k
);
  localparam int NS  = (CORDIC_STEPS > e2q_pkg::TABLE_LEN) ? e2q_pkg::TABLE_LEN
                                                           : CORDIC_STEPS;
  localparam int NST = NS + 9;
  localparam longint X0 = e2q_pkg::KINF_Q30 +
                          ((e2q_pkg::KINF_Q30 * 2 / 3) >>> (2 * NS));
  // reciprocal of 360: mag*2^(31-F) < 2^41, multiply by ceil(2^50/360)
  localparam int SH = 31 - ANGLE_FRAC_BITS;
  localparam longint RECIP = (64'sd1 <<< 50) / 360 + 1;

  logic adv;
  logic [NST-1:0] vld_r;
  assign adv       = out_tready || !out_tvalid;
  assign in_tready = adv;
  assign out_tvalid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NST-2:0], in_tvalid};
  end

  // ---- stage 0: magnitude and scaled numerator
  logic        neg_r [3];
  logic [41:0] num_r [3];
  // ---- stage 1: partial products by the reciprocal (high and low halves)
  logic        neg1_r [3];
  logic [62:0] ph_r [3];
  logic [62:0] pl_r [3];
  // ---- CORDIC state per stage
  logic signed [33:0] cx_r [NS+1][3];
  logic signed [33:0] cy_r [NS+1][3];
  logic signed [32:0] cz_r [NS+1][3];
  logic [1:0]         qd_r [NS+1][3];
  // ---- quadrant fix
  logic signed [33:0] co_r [3];
  logic signed [33:0] si_r [3];

  for (genvar a = 0; a < 3; a++) begin : g_ang
    logic signed [16:0] ang;
    logic [16:0] mag;
    logic [83:0] prod;
    logic [31:0] bq;
    logic [31:0] bam;
    assign ang = in_tdata[17*a +: 17];
    assign mag = ang[16] ? 17'(-ang) : ang;
    always_ff @(posedge clk) if (adv) begin
      neg_r[a] <= ang[16];
      num_r[a] <= (42'(mag) << SH) + 42'd180;
    end
    // reciprocal error stays below 2^-9, so the quotient estimate is exact
    always_ff @(posedge clk) if (adv) begin
      neg1_r[a] <= neg_r[a];
      ph_r[a]   <= 63'(num_r[a][41:21]) * 63'(RECIP);
      pl_r[a]   <= 63'(num_r[a][20:0]) * 63'(RECIP);
    end
    assign prod = (84'(ph_r[a]) << 21) + 84'(pl_r[a]);
    assign bq   = 32'(prod >> 50);
    assign bam  = neg1_r[a] ? -bq : bq;
    always_ff @(posedge clk) if (adv) begin
      cx_r[0][a] <= 34'(X0);
      cy_r[0][a] <= '0;
      cz_r[0][a] <= {3'b000, bam[29:0]};
      qd_r[0][a] <= bam[31:30];
    end
    // one CORDIC iteration per stage
    for (genvar i = 0; i < NS; i++) begin : g_it
      logic [32:0] at;
      assign at = {1'b0, e2q_pkg::atan_bam(i)};
      always_ff @(posedge clk) if (adv) begin
        qd_r[i+1][a] <= qd_r[i][a];
        if (!cz_r[i][a][32]) begin
          cx_r[i+1][a] <= cx_r[i][a] - (cy_r[i][a] >>> i);
          cy_r[i+1][a] <= cy_r[i][a] + (cx_r[i][a] >>> i);
          cz_r[i+1][a] <= cz_r[i][a] - at;
        end else begin
          cx_r[i+1][a] <= cx_r[i][a] + (cy_r[i][a] >>> i);
          cy_r[i+1][a] <= cy_r[i][a] - (cx_r[i][a] >>> i);
          cz_r[i+1][a] <= cz_r[i][a] + at;
        end
      end
    end
    always_ff @(posedge clk) if (adv) begin
      case (qd_r[NS][a])
        2'd0: begin co_r[a] <= cx_r[NS][a];  si_r[a] <= cy_r[NS][a];  end
        2'd1: begin co_r[a] <= -cy_r[NS][a]; si_r[a] <= cx_r[NS][a];  end
        2'd2: begin co_r[a] <= -cx_r[NS][a]; si_r[a] <= -cy_r[NS][a]; end
        default: begin co_r[a] <= cy_r[NS][a]; si_r[a] <= -cx_r[NS][a]; end
      endcase
    end
  end

  // ---- pair products (a=0 roll, 1 pitch, 2 yaw)
  logic signed [67:0] pp_r [4];
  logic signed [33:0] cr1_r, sr1_r, cr2_r, sr2_r;
  always_ff @(posedge clk) if (adv) begin
    pp_r[0] <= co_r[2] * co_r[1];
    pp_r[1] <= si_r[2] * si_r[1];
    pp_r[2] <= co_r[2] * si_r[1];
    pp_r[3] <= si_r[2] * co_r[1];
    cr1_r <= co_r[0]; sr1_r <= si_r[0];
  end
  logic signed [33:0] pq_r [4];
  always_ff @(posedge clk) if (adv) begin
    for (int k = 0; k < 4; k++) pq_r[k] <= 34'((pp_r[k] + 68'sd536870912) >>> 30);
    cr2_r <= cr1_r; sr2_r <= sr1_r;
  end
  // triple products, eight of them
  logic signed [67:0] tp_r [8];
  always_ff @(posedge clk) if (adv) begin
    tp_r[0] <= pq_r[0] * cr2_r; tp_r[1] <= pq_r[1] * sr2_r;
    tp_r[2] <= pq_r[0] * sr2_r; tp_r[3] <= pq_r[1] * cr2_r;
    tp_r[4] <= pq_r[2] * cr2_r; tp_r[5] <= pq_r[3] * sr2_r;
    tp_r[6] <= pq_r[3] * cr2_r; tp_r[7] <= pq_r[2] * sr2_r;
  end
  logic signed [68:0] sm_r [4];
  always_ff @(posedge clk) if (adv) begin
    sm_r[0] <= 69'(tp_r[0]) + 69'(tp_r[1]);
    sm_r[1] <= 69'(tp_r[2]) - 69'(tp_r[3]);
    sm_r[2] <= 69'(tp_r[4]) + 69'(tp_r[5]);
    sm_r[3] <= 69'(tp_r[6]) - 69'(tp_r[7]);
  end
  // round to Q15 and saturate
  logic [15:0] q_r [4];
  for (genvar k = 0; k < 4; k++) begin : g_out
    logic signed [68:0] r;
    assign r = (sm_r[k] + (69'sd1 <<< 44)) >>> 45;
    always_ff @(posedge clk) if (adv) begin
      if (r > 69'sd32767) q_r[k] <= 16'h7FFF;
      else if (r < -69'sd32768) q_r[k] <= 16'h8000;
      else q_r[k] <= r[15:0];
    end
  end
  assign out_tdata = {q_r[3], q_r[2], q_r[1], q_r[0]};

  // ---- checks
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (out_tready || !out_tvalid))
    else $error("ready mismatch");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved while stalled");
endmodule
`default_nettype wire
